/* hdl/mqsfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsfp_pkg
// shared types and constants of the byte-serial mqtt-sn message parser
// ----------------------------------------------------------------------------
package mqsfp_pkg;

    localparam int ADDR_MAX    = 31;
    localparam int ADDR_CNT_W  = $clog2(ADDR_MAX + 1);
    localparam int ADDR_IDX_W  = 5;
    localparam int OUT_DATA_W  = 72;

    localparam logic [7:0] LONG_MARK  = 8'h01;
    localparam logic [2:0] HLEN_SHORT = 3'd2;
    localparam logic [2:0] HLEN_LONG  = 3'd4;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_HEADER    = 2'd1;
    localparam logic [1:0] EV_ADVERTISE = 2'd2;
    localparam logic [1:0] EV_GW_ADDR   = 2'd3;

    localparam logic CFG_ADVERTISE = 1'b0;
    localparam logic CFG_GWINFO    = 1'b1;

    typedef struct packed {
        logic [15:0]           byte_count;
        logic                  length_done;
        logic                  header_done;
        logic                  long_form;
        logic [15:0]           total_length;
        logic [7:0]            type_held;
        logic [7:0]            gateway_held;
        logic [7:0]            duration_high;
        logic [ADDR_CNT_W-1:0] addr_count;
    } t_state;

    typedef struct packed {
        logic [1:0]            event_res;
        logic [15:0]           msg_length;
        logic [7:0]            msg_type;
        logic [2:0]            header_len;
        logic [7:0]            gw_id;
        logic [15:0]           duration;
        logic [7:0]            addr_byte;
        logic [ADDR_IDX_W-1:0] addr_index;
        logic                  addr_last;
        logic                  addr_overflow;
        logic                  msg_end;
        logic                  malformed;
    } t_result;

endpackage

/* hdl/mqsfp_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsfp_step
// per-byte update: next parser state and the result of one received byte
// ----------------------------------------------------------------------------
module mqsfp_step (
    input  mqsfp_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_adv_code,
    input  logic [7:0]         i_gw_code,
    output mqsfp_pkg::t_state  o_state,
    output mqsfp_pkg::t_result o_res
);

    mqsfp_pkg::t_state  n_st;
    mqsfp_pkg::t_result n_res;
    logic               len_now;
    logic [15:0]        hlen_w;
    logic [15:0]        off;
    logic [16:0]        cnt_plus;

    always_comb begin
        n_st    = i_state;
        n_res   = '0;
        len_now = 1'b0;
        hlen_w   = i_state.long_form ? 16'(mqsfp_pkg::HLEN_LONG)
                                     : 16'(mqsfp_pkg::HLEN_SHORT);
        off      = i_state.byte_count - hlen_w;
        cnt_plus = {1'b0, i_state.byte_count} + 17'd1;

        if (!i_state.header_done) begin
            if (!i_state.length_done) begin
                if (i_state.byte_count == 16'd0) begin
                    if (i_byte != mqsfp_pkg::LONG_MARK) begin
                        n_st.total_length = {8'd0, i_byte};
                        n_st.long_form    = 1'b0;
                        n_st.length_done  = 1'b1;
                        len_now           = 1'b1;
                    end else begin
                        n_st.long_form = 1'b1;
                    end
                end else if (i_state.byte_count == 16'd1) begin
                    n_st.total_length = {i_byte, 8'd0};
                end else begin
                    n_st.total_length = {i_state.total_length[15:8], i_byte};
                    n_st.length_done  = 1'b1;
                    len_now           = 1'b1;
                end
            end else begin
                n_st.type_held   = i_byte;
                n_st.header_done = 1'b1;
                n_res.event_res  = mqsfp_pkg::EV_HEADER;
            end
        end else if (i_state.type_held == i_adv_code) begin
            if (off == 16'd0) begin
                n_st.gateway_held = i_byte;
            end else if (off == 16'd1) begin
                n_st.duration_high = i_byte;
            end else if (off == 16'd2) begin
                n_res.duration  = {i_state.duration_high, i_byte};
                n_res.event_res = mqsfp_pkg::EV_ADVERTISE;
            end
        end else if (i_state.type_held == i_gw_code) begin
            if (off == 16'd0) begin
                n_st.gateway_held = i_byte;
            end else begin
                n_res.event_res  = mqsfp_pkg::EV_GW_ADDR;
                n_res.addr_byte  = i_byte;
                n_res.addr_index = mqsfp_pkg::ADDR_IDX_W'(i_state.addr_count);
                n_res.addr_last  = (cnt_plus == {1'b0, i_state.total_length});
                if (i_state.addr_count >= mqsfp_pkg::ADDR_CNT_W'(mqsfp_pkg::ADDR_MAX)) begin
                    n_res.addr_overflow = 1'b1;
                end else begin
                    n_st.addr_count = i_state.addr_count + mqsfp_pkg::ADDR_CNT_W'(1);
                end
            end
        end

        n_st.byte_count = cnt_plus[15:0];
        if (n_st.length_done) begin
            if (len_now && (n_st.total_length < n_st.byte_count)) begin
                n_res.msg_end   = 1'b1;
                n_res.malformed = 1'b1;
            end else if (n_st.byte_count == n_st.total_length) begin
                n_res.msg_end = 1'b1;
            end
        end

        n_res.msg_length = n_st.total_length;
        n_res.msg_type   = n_st.type_held;
        n_res.header_len = n_st.long_form ? mqsfp_pkg::HLEN_LONG : mqsfp_pkg::HLEN_SHORT;
        n_res.gw_id      = n_st.gateway_held;

        if (n_res.msg_end) begin
            n_st = '0;
        end
    end

    assign o_state = n_st;
    assign o_res   = n_res;

endmodule

/* hdl/mqtt_sn_frame_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_sn_frame_parser_core
// byte-serial mqtt-sn message parser, one result beat per received byte
//
//   channel   dir  payload
//   s         in   tdata[7:0] rx_byte
//   m         out  tuser event_res, tlast msg_end, tdata result fields
//   cfg       in   we / index / data, 0 advertise_code, 1 gwinfo_code
//
// one byte per cycle while the result side is not stalled; the result of a taken byte is registered.
// the parser state and the result register update in the same cycle.
// synchronous active-low reset clears the parser and restores the default type codes.
// a stalled result holds; a new byte is taken whenever the result
// register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module mqtt_sn_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [mqsfp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // [15:0] msg_length, [23:16] msg_type, [26:24] header_len, [34:27] gw_id,
    // [50:35] duration, [58:51] addr_byte, [63:59] addr_index, [64] addr_last,
    // [65] addr_overflow, [66] malformed, [71:67] zero
    output logic [1:0]  o_m_tuser,   // [1:0] event_res
    output logic        o_m_tlast,   // msg_end
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    mqsfp_pkg::t_state  r_state;
    mqsfp_pkg::t_state  n_state;
    mqsfp_pkg::t_result r_res;
    mqsfp_pkg::t_result n_res;
    logic [7:0]         r_adv_code;
    logic [7:0]         r_gw_code;
    logic               r_valid;
    logic               accept;

    assign o_s_tready = !r_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    mqsfp_step u_step (
        .i_state    (r_state),
        .i_byte     (i_s_tdata),
        .i_adv_code (r_adv_code),
        .i_gw_code  (r_gw_code),
        .o_state    (n_state),
        .o_res      (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '0;
            r_valid    <= 1'b0;
            r_adv_code <= 8'd0;
            r_gw_code  <= 8'd2;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mqsfp_pkg::CFG_ADVERTISE: r_adv_code <= i_cfg_data;
                    mqsfp_pkg::CFG_GWINFO:    r_gw_code  <= i_cfg_data;
                    default:                  r_gw_code  <= r_gw_code;
                endcase
            end
            if (accept) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_res.event_res;
    assign o_m_tlast  = r_res.msg_end;
    assign o_m_tdata  = {5'd0, r_res.malformed, r_res.addr_overflow, r_res.addr_last,
                         r_res.addr_index, r_res.addr_byte, r_res.duration,
                         r_res.gw_id, r_res.header_len, r_res.msg_type,
                         r_res.msg_length};

endmodule

/* hdl/mqsfp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsfp_checker
// port-level checks of the mqtt-sn parser result stream
// ----------------------------------------------------------------------------
module mqsfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [mqsfp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result register");

    a_malformed_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[66] |-> o_m_tlast && o_m_tuser == mqsfp_pkg::EV_NONE)
        else $error("malformed beat does not end the message");

    a_overflow_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[65] |-> o_m_tuser == mqsfp_pkg::EV_GW_ADDR)
        else $error("address overflow outside an address beat");

    a_hlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[26:24] == mqsfp_pkg::HLEN_SHORT
                    || o_m_tdata[26:24] == mqsfp_pkg::HLEN_LONG)
        else $error("header length neither short nor long form");

endmodule

bind mqtt_sn_frame_parser_core mqsfp_checker u_mqsfp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

/* bench/mqtt_sn_frame_parser_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_sn_frame_parser_core_test
// self-checking bench for the byte-serial mqtt-sn message parser
//
// Bytes go in on the slave stream and each one is predicted right away as it
// is taken. Each result beat is then checked field by field against the oldest
// prediction that is still waiting. A short directed run covers the
// zero-length and short-length cases, the three-byte long form, and the
// advertise, gwinfo and other-type paths. Random phases follow, each with
// different type codes (the extremes and equal codes among them). Most of
// those messages are well formed, and some are broken or overflow the address
// store. Both stream sides pause at random, and one phase runs with no pauses.
// ----------------------------------------------------------------------------

class parser_scoreboard;
    logic [7:0]                       adv_code;
    logic [7:0]                       gw_code;
    logic [15:0]                      byte_count;
    logic                             length_done;
    logic                             header_done;
    logic                             long_form;
    logic [15:0]                      total_length;
    logic [7:0]                       type_held;
    logic [7:0]                       gateway_held;
    logic [7:0]                       duration_high;
    logic [mqsfp_pkg::ADDR_CNT_W-1:0] addr_count;
    mqsfp_pkg::t_result               expected_q[$];
    int unsigned                      mismatches;

    function new();
        adv_code   = 8'h00;
        gw_code    = 8'h02;
        mismatches = 0;
        clear_message();
    endfunction

    function void clear_message();
        byte_count    = '0;
        length_done   = 1'b0;
        header_done   = 1'b0;
        long_form     = 1'b0;
        total_length  = '0;
        type_held     = '0;
        gateway_held  = '0;
        duration_high = '0;
        addr_count    = '0;
    endfunction

    function void set_code(input logic idx, input logic [7:0] val);
        if (idx == mqsfp_pkg::CFG_ADVERTISE)
            adv_code = val;
        else
            gw_code = val;
    endfunction

    function bit at_msg_start();
        return byte_count == 16'd0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // predict the result beat of one accepted byte
    function void note_byte(input logic [7:0] b);
        mqsfp_pkg::t_result r;
        logic               len_now;
        logic [15:0]        off;
        r       = '0;
        len_now = 1'b0;
        if (!header_done) begin
            if (!length_done) begin
                if (byte_count == 16'd0) begin
                    if (b != mqsfp_pkg::LONG_MARK) begin
                        total_length = {8'd0, b};
                        long_form    = 1'b0;
                        length_done  = 1'b1;
                        len_now      = 1'b1;
                    end else begin
                        long_form = 1'b1;
                    end
                end else if (byte_count == 16'd1) begin
                    total_length = {b, 8'd0};
                end else begin
                    total_length = total_length | {8'd0, b};
                    length_done  = 1'b1;
                    len_now      = 1'b1;
                end
            end else begin
                type_held   = b;
                header_done = 1'b1;
                r.event_res = mqsfp_pkg::EV_HEADER;
            end
        end else begin
            off = byte_count - (long_form ? 16'd4 : 16'd2);
            if (type_held == adv_code) begin
                if (off == 16'd0) begin
                    gateway_held = b;
                end else if (off == 16'd1) begin
                    duration_high = b;
                end else if (off == 16'd2) begin
                    r.duration  = {duration_high, b};
                    r.event_res = mqsfp_pkg::EV_ADVERTISE;
                end
            end else if (type_held == gw_code) begin
                if (off == 16'd0) begin
                    gateway_held = b;
                end else begin
                    r.event_res  = mqsfp_pkg::EV_GW_ADDR;
                    r.addr_byte  = b;
                    r.addr_index = addr_count[mqsfp_pkg::ADDR_IDX_W-1:0];
                    r.addr_last  = (byte_count + 16'd1 == total_length);
                    if (addr_count >= mqsfp_pkg::ADDR_MAX)
                        r.addr_overflow = 1'b1;
                    else
                        addr_count = addr_count + 1'b1;
                end
            end
        end

        byte_count = byte_count + 16'd1;
        if (length_done) begin
            if (len_now && total_length < byte_count) begin
                r.msg_end   = 1'b1;
                r.malformed = 1'b1;
            end else if (byte_count == total_length) begin
                r.msg_end = 1'b1;
            end
        end

        r.msg_length = total_length;
        r.msg_type   = type_held;
        r.header_len = long_form ? mqsfp_pkg::HLEN_LONG : mqsfp_pkg::HLEN_SHORT;
        r.gw_id      = gateway_held;
        expected_q.push_back(r);
        if (r.msg_end)
            clear_message();
    endfunction

    function void compare(input string name, input logic [15:0] want,
                          input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    function void check_beat(input logic [1:0] ev, input logic last,
                             input logic [mqsfp_pkg::OUT_DATA_W-1:0] data);
        mqsfp_pkg::t_result want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result beat with no byte waiting: tuser 0x%0h tdata 0x%0h",
                         ev, data);
            return;
        end
        want = expected_q.pop_front();
        compare("event_res", 16'(want.event_res), 16'(ev));
        compare("msg_length", want.msg_length, data[15:0]);
        compare("msg_type", 16'(want.msg_type), 16'(data[23:16]));
        compare("header_len", 16'(want.header_len), 16'(data[26:24]));
        compare("gw_id", 16'(want.gw_id), 16'(data[34:27]));
        compare("duration", want.duration, data[50:35]);
        compare("addr_byte", 16'(want.addr_byte), 16'(data[58:51]));
        compare("addr_index", 16'(want.addr_index), 16'(data[63:59]));
        compare("addr_last", 16'(want.addr_last), 16'(data[64]));
        compare("addr_overflow", 16'(want.addr_overflow), 16'(data[65]));
        compare("malformed", 16'(want.malformed), 16'(data[66]));
        compare("tdata pad", 16'd0, 16'(data[71:67]));
        compare("msg_end", 16'(want.msg_end), 16'(last));
    endfunction
endclass

module mqtt_sn_frame_parser_core_test;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    logic [7:0]                       i_s_tdata;
    logic                             o_m_tvalid;
    logic                             i_m_tready;
    logic [mqsfp_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic [1:0]                       o_m_tuser;
    logic                             o_m_tlast;
    logic                             i_cfg_we;
    logic                             i_cfg_index;
    logic [7:0]                       i_cfg_data;

    parser_scoreboard sb;
    bit               feed_gaps;
    bit               sink_stalls;
    int               bytes_fed;

    mqtt_sn_frame_parser_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pause_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] payload_byte();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (feed_gaps && $urandom_range(0, 2) == 0) ? pause_len() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.note_byte(b);
        bytes_fed++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_codes(input logic [7:0] adv, input logic [7:0] gw);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mqsfp_pkg::CFG_ADVERTISE;
        i_cfg_data  <= adv;
        @(negedge i_clk);
        i_cfg_index <= mqsfp_pkg::CFG_GWINFO;
        i_cfg_data  <= gw;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_code(mqsfp_pkg::CFG_ADVERTISE, adv);
        sb.set_code(mqsfp_pkg::CFG_GWINFO, gw);
    endtask

    // one message; bytes keep coming until the parser is back at a message start
    task automatic send_message();
        int         pick;
        int         len;
        logic [7:0] ty;
        bit         long_hdr;
        pick = $urandom_range(0, 11);
        if (pick < 4)
            ty = sb.adv_code;
        else if (pick < 7)
            ty = sb.gw_code;
        else
            ty = 8'($urandom_range(0, 255));
        if (pick == 11)
            len = $urandom_range(0, 3);
        else if (pick >= 4 && pick < 7 && $urandom_range(0, 2) == 0)
            len = $urandom_range(33, 45);
        else
            len = $urandom_range(2, 12);
        long_hdr = (len == 1) || ($urandom_range(0, 3) == 0);
        if (long_hdr) begin
            send_byte(mqsfp_pkg::LONG_MARK);
            send_byte(8'h00);
        end
        send_byte(len[7:0]);
        if (!sb.at_msg_start())
            send_byte(ty);
        while (!sb.at_msg_start())
            send_byte(payload_byte());
    endtask

    task automatic run_phase(input logic [7:0] adv, input logic [7:0] gw, input bit stalls);
        int target;
        write_codes(adv, gw);
        feed_gaps   = stalls;
        sink_stalls = stalls;
        target      = bytes_fed + 100;
        while (bytes_fed < target) begin
            send_message();
            if ($urandom_range(0, 14) == 0)
                drain();
        end
        drain();
    endtask

    task automatic run_directed();
        logic [7:0] seq[$];
        // zero length, long zero, long three, header only, advertise with
        // trailing byte, long-form gwinfo with one address byte, other type
        seq = '{8'h00,
                8'h01, 8'h00, 8'h00,
                8'h01, 8'h00, 8'h03,
                8'h02, 8'h07,
                8'h06, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                8'h01, 8'h00, 8'h06, 8'h02, 8'h00, 8'h80,
                8'h03, 8'hFF, 8'h55};
        foreach (seq[k])
            send_byte(seq[k]);
        drain();
    endtask

    initial begin : sink
        int hold;
        hold       = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!sink_stalls || !i_m_tready) begin
                i_m_tready <= 1'b1;
                hold = $urandom_range(0, 15);
            end else begin
                i_m_tready <= 1'b0;
                hold = pause_len() - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1)
            sb.check_beat(o_m_tuser, o_m_tlast, o_m_tdata);
    end

    initial begin : stimulus
        sb          = new();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = 8'h00;
        i_cfg_we    = 1'b0;
        i_cfg_index = mqsfp_pkg::CFG_ADVERTISE;
        i_cfg_data  = 8'h00;
        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
        bytes_fed   = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_phase(8'hFF, 8'h00, 1'b1);
        run_phase(8'h5A, 8'h5A, 1'b1);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
        run_phase(8'h00, 8'hFF, 1'b1);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
hdl/mqsfp_pkg.sv
hdl/mqsfp_step.sv
hdl/mqtt_sn_frame_parser_core.sv
hdl/mqsfp_checker.sv
bench/mqtt_sn_frame_parser_core_test.sv
